@@ rtl/core/prd_pkg.sv @@
`timescale 1ns / 1ps
package prd_pkg;

	// Fixed field widths
	localparam int COORD_W    = 16;
	localparam int SIZE_W     = 13;
	localparam int FOV_W      = 20;
	localparam int P16_W      = 24;
	localparam int MAT_W      = 21;
	localparam int ROW_W      = 63;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 63;
	localparam int NORM_BITS  = 31;
	localparam int RAD_W      = 64;
	localparam int ROOT_W     = 32;
	localparam int ISQRT_STEPS = 32;

	// Parameter defaults
	localparam int DEF_COORD_INT_BITS = 12;
	localparam int DEF_DIR_FRAC_BITS  = 19;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_FOV_TANGENT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ASPECT_RATIO     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION_ROW0    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION_ROW1    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATION_ROW2    = 3'd6;

	// Reset values
	localparam logic [SIZE_W-1:0] SIZE_RST = 13'd1024;
	localparam logic [FOV_W-1:0]  FOV_RST  = 20'd65536;
	localparam logic [P16_W-1:0]  P16_RST  = 24'd65536;
	localparam logic [ROW_W-1:0]  ROW0_RST = 63'd524288;
	localparam logic [ROW_W-1:0]  ROW1_RST = 63'd1099511627776;
	localparam logic [ROW_W-1:0]  ROW2_RST = 63'd2305843009213693952;

endpackage

@@ rtl/core/prd_if.sv @@
`timescale 1ns / 1ps
interface prd_pix_if import prd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface prd_dir_if import prd_pkg::*; #(parameter int DW = DEF_DIR_FRAC_BITS + 2) ();
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] dir_x;
	logic signed [DW-1:0] dir_y;
	logic signed [DW-1:0] dir_z;
	modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
	modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface prd_cfg_if import prd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/pinhole_primary_ray_direction.sv @@
`timescale 1ns / 1ps
// Pinhole camera primary ray direction generator.
// pix carries one pixel coordinate per transaction (unsigned fixed point,
// COORD_INT_BITS integer bits); dir returns one unit direction per pixel,
// signed Q1.DIR_FRAC_BITS, in input order.
// cfg writes a register by index (0 width, 1 height, 2 half-fov tangent,
// 3 aspect ratio, 4..6 rotation rows); write only while the pipeline is empty.
// Throughput: one transaction per clock unless dir stalls. The pipeline holds
// the bit-per-stage coordinate divider (DIR_FRAC_BITS+18 stages), the
// 32-stage square root and the output divider (DIR_FRAC_BITS+1 stages),
// plus thirteen arithmetic stages.
// Reset clears all stage valid bits and loads the identity camera:
// 1024x1024, tangent 1.0, aspect 1.0, identity rotation.
// When dir stalls the whole pipeline holds; pix.ready drops only while a
// finished result waits at the output and dir.ready is low.
module pinhole_primary_ray_direction import prd_pkg::*; #(
	parameter int COORD_INT_BITS = DEF_COORD_INT_BITS,
	parameter int DIR_FRAC_BITS  = DEF_DIR_FRAC_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	prd_cfg_if.sink   cfg,
	prd_pix_if.sink   pix,
	prd_dir_if.source dir
);

	localparam int F    = DIR_FRAC_BITS;
	localparam int CF   = COORD_W - COORD_INT_BITS;
	localparam int CDW  = SIZE_W + CF;
	localparam int CNW  = COORD_W + 2 + F;
	localparam int PLW  = CNW + P16_W / 2;
	localparam int PRW  = CNW + P16_W + 1;
	localparam int CW   = F + 2;
	localparam int MW   = MAT_W + CW;
	localparam int WW   = MW + 2;
	localparam int MGW  = WW - 2;
	localparam int NBW  = $clog2(MGW + 1);
	localparam int SQW  = 2 * NORM_BITS;
	localparam int SBQ  = 4 + 3 * NORM_BITS;
	localparam int ONW  = NORM_BITS + 1 + F;
	localparam int QW2  = F + 1;
	localparam int OW   = F + 2;

	localparam logic [CNW:0]           ONE_C = (CNW + 1)'(1) << F;
	localparam logic [CW-1:0]          TOP   = CW'(1) << (F + 1);
	localparam logic signed [CW-1:0]   CZ    = {2'b11, {F{1'b0}}};

	// Configuration registers
	logic [SIZE_W-1:0] width_q, height_q;
	logic [FOV_W-1:0]  tan_q, aspect_q;
	logic [ROW_W-1:0]  row_q [3];
	logic [P16_W-1:0]  p16_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RST;
			height_q <= SIZE_RST;
			tan_q    <= FOV_RST;
			aspect_q <= FOV_RST;
			row_q[0] <= ROW0_RST;
			row_q[1] <= ROW1_RST;
			row_q[2] <= ROW2_RST;
			p16_q    <= P16_RST;
		end else begin
			p16_q <= P16_W'((41'(aspect_q * tan_q) + 41'(1 << 15)) >> 16);
			if (cfg.valid) begin
				case (cfg.index)
					REG_IMAGE_WIDTH:      width_q  <= cfg.data[SIZE_W-1:0];
					REG_IMAGE_HEIGHT:     height_q <= cfg.data[SIZE_W-1:0];
					REG_HALF_FOV_TANGENT: tan_q    <= cfg.data[FOV_W-1:0];
					REG_ASPECT_RATIO:     aspect_q <= cfg.data[FOV_W-1:0];
					REG_ROTATION_ROW0:    row_q[0] <= cfg.data[ROW_W-1:0];
					REG_ROTATION_ROW1:    row_q[1] <= cfg.data[ROW_W-1:0];
					REG_ROTATION_ROW2:    row_q[2] <= cfg.data[ROW_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Global advance: the whole pipeline moves unless the output is blocked
	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic vld_s9, vld_s10, vld_s11, vld_s12, vld_s13;
	logic cdiv_vld, sq_vld, fdiv_vld;

	assign adv       = !vld_s13 || dir.ready;
	assign pix.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= pix.valid;
			vld_s2  <= cdiv_vld;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= sq_vld;
			vld_s13 <= fdiv_vld;
		end
	end

	// Stage 1: build rounded coordinate numerators and divisors
	logic [1:0][CNW-1:0] cnum_s1;
	logic [1:0][CDW-1:0] cden_s1;

	always_ff @(posedge clk) begin
		logic [SIZE_W-1:0] wx, hy;
		logic [CDW-1:0]    dx, dy;
		if (adv) begin
			wx = (width_q == '0) ? SIZE_W'(1) : width_q;
			hy = (height_q == '0) ? SIZE_W'(1) : height_q;
			dx = CDW'(wx) << CF;
			dy = CDW'(hy) << CF;
			cden_s1[0] <= dx;
			cden_s1[1] <= dy;
			cnum_s1[0] <= (CNW'(pix.pixel_x) << (F + 1)) + CNW'(dx >> 1);
			cnum_s1[1] <= (CNW'(pix.pixel_y) << (F + 1)) + CNW'(dy >> 1);
		end
	end

	logic [1:0][CNW-1:0] cquo;

	prd_div #(
		.LANES(2), .NW(CNW), .DW(CDW), .QW(CNW), .SBW(1)
	) u_cdiv (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(vld_s1),
		.num(cnum_s1), .den(cden_s1), .sb_in(1'b0),
		.out_vld(cdiv_vld), .quo(cquo), .sb_out()
	);

	// Stage 2: center the ratios, take sign and magnitude
	logic [CNW-1:0] mag_s2 [2];
	logic           neg_s2 [2];

	always_ff @(posedge clk) begin
		logic [CNW:0] u, v;
		if (adv) begin
			u = {1'b0, cquo[0]} - ONE_C;
			v = ONE_C - {1'b0, cquo[1]};
			neg_s2[0] <= u[CNW];
			neg_s2[1] <= v[CNW];
			mag_s2[0] <= u[CNW] ? CNW'(-u) : u[CNW-1:0];
			mag_s2[1] <= v[CNW] ? CNW'(-v) : v[CNW-1:0];
		end
	end

	// Stage 3: partial products against the lens scale
	logic [PLW-1:0] pl_s3 [2];
	logic [PLW-1:0] ph_s3 [2];
	logic           neg_s3 [2];

	always_ff @(posedge clk) begin
		logic [P16_W-1:0] p [2];
		if (adv) begin
			p[0] = p16_q;
			p[1] = P16_W'(tan_q);
			for (int l = 0; l < 2; l++) begin
				pl_s3[l]  <= mag_s2[l] * p[l][P16_W/2-1:0];
				ph_s3[l]  <= mag_s2[l] * p[l][P16_W-1:P16_W/2];
				neg_s3[l] <= neg_s2[l];
			end
		end
	end

	// Stage 4: combine, round, saturate, restore the sign
	logic signed [CW-1:0] c_s4 [2];

	always_ff @(posedge clk) begin
		logic [PRW-1:0] prd, rnd;
		logic [CW-1:0]  lim, rc;
		if (adv) begin
			for (int l = 0; l < 2; l++) begin
				prd = PRW'(pl_s3[l]) + (PRW'(ph_s3[l]) << (P16_W / 2));
				rnd = (prd + PRW'(1 << 15)) >> 16;
				lim = neg_s3[l] ? TOP : TOP - CW'(1);
				rc  = (rnd > PRW'(lim)) ? lim : rnd[CW-1:0];
				c_s4[l] <= neg_s3[l] ? signed'(CW'(0) - rc) : signed'(rc);
			end
		end
	end

	// Stage 5: the nine rotation products
	logic signed [MAT_W-1:0] m_ent [3][3];
	logic signed [CW-1:0]    c_vec [3];
	logic signed [MW-1:0]    prd_s5 [3][3];

	always_comb begin
		c_vec[0] = c_s4[0];
		c_vec[1] = c_s4[1];
		c_vec[2] = CZ;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				m_ent[i][j] = signed'(row_q[i][MAT_W*j +: MAT_W]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prd_s5[i][j] <= m_ent[i][j] * c_vec[j];
				end
			end
		end
	end

	// Stage 6: row sums, sign and magnitude
	logic [MGW-1:0] mag_s6 [3];
	logic [2:0]     neg_s6;

	always_ff @(posedge clk) begin
		logic signed [WW-1:0] w;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				w = prd_s5[i][0] + prd_s5[i][1] + prd_s5[i][2];
				neg_s6[i] <= w[WW-1];
				mag_s6[i] <= w[WW-1] ? MGW'(-w) : MGW'(w);
			end
		end
	end

	// Stage 7: largest magnitude
	logic [MGW-1:0] mag_s7 [3];
	logic [2:0]     neg_s7;
	logic [MGW-1:0] mx_s7;

	always_ff @(posedge clk) begin
		logic [MGW-1:0] m01;
		if (adv) begin
			m01 = (mag_s6[1] > mag_s6[0]) ? mag_s6[1] : mag_s6[0];
			mx_s7  <= (mag_s6[2] > m01) ? mag_s6[2] : m01;
			mag_s7 <= mag_s6;
			neg_s7 <= neg_s6;
		end
	end

	// Stage 8: bit length of the largest magnitude
	logic [MGW-1:0] mag_s8 [3];
	logic [2:0]     neg_s8;
	logic [NBW-1:0] nb_s8;

	always_ff @(posedge clk) begin
		logic [NBW-1:0] nb;
		if (adv) begin
			nb = '0;
			for (int b = 0; b < MGW; b++) begin
				if (mx_s7[b]) begin
					nb = NBW'(b + 1);
				end
			end
			nb_s8  <= nb;
			mag_s8 <= mag_s7;
			neg_s8 <= neg_s7;
		end
	end

	// Stage 9: block shift so the largest has NORM_BITS bits
	logic [NORM_BITS-1:0] mag_s9 [3];
	logic [2:0]           neg_s9;
	logic                 zero_s9;

	always_ff @(posedge clk) begin
		logic [MGW-1:0] t;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (nb_s8 > NBW'(NORM_BITS)) begin
					t = mag_s8[i] >> (nb_s8 - NBW'(NORM_BITS));
				end else begin
					t = mag_s8[i] << (NBW'(NORM_BITS) - nb_s8);
				end
				mag_s9[i] <= t[NORM_BITS-1:0];
			end
			neg_s9  <= neg_s8;
			zero_s9 <= (nb_s8 == '0);
		end
	end

	// Stage 10: squares
	logic [SQW-1:0]       sq_s10 [3];
	logic [NORM_BITS-1:0] mag_s10 [3];
	logic [2:0]           neg_s10;
	logic                 zero_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s10[i] <= mag_s9[i] * mag_s9[i];
			end
			mag_s10  <= mag_s9;
			neg_s10  <= neg_s9;
			zero_s10 <= zero_s9;
		end
	end

	// Stage 11: sum of squares
	logic [RAD_W-1:0] sum_s11;
	logic [SBQ-1:0]   sb_s11;

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s11 <= RAD_W'(sq_s10[0]) + RAD_W'(sq_s10[1]) + RAD_W'(sq_s10[2]);
			sb_s11  <= {zero_s10, neg_s10, mag_s10[2], mag_s10[1], mag_s10[0]};
		end
	end

	logic [ROOT_W-1:0] root;
	logic [SBQ-1:0]    sb_sq;

	prd_isqrt #(
		.SBW(SBQ)
	) u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(vld_s11),
		.rad(sum_s11), .sb_in(sb_s11),
		.out_vld(sq_vld), .root(root), .sb_out(sb_sq)
	);

	// Stage 12: rounded numerators over the norm
	logic [2:0][ONW-1:0]    fnum_s12;
	logic [2:0][ROOT_W-1:0] fden_s12;
	logic [3:0]             fsb_s12;

	always_ff @(posedge clk) begin
		logic [NORM_BITS-1:0] m;
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				m = sb_sq[NORM_BITS*i +: NORM_BITS];
				fnum_s12[i] <= (ONW'(m) << F) + ONW'(root >> 1);
				fden_s12[i] <= root;
			end
			fsb_s12 <= sb_sq[SBQ-1 -: 4];
		end
	end

	logic [2:0][QW2-1:0] fquo;
	logic [3:0]          fsb;

	prd_div #(
		.LANES(3), .NW(ONW), .DW(ROOT_W), .QW(QW2), .SBW(4)
	) u_fdiv (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_vld(vld_s12),
		.num(fnum_s12), .den(fden_s12), .sb_in(fsb_s12),
		.out_vld(fdiv_vld), .quo(fquo), .sb_out(fsb)
	);

	// Stage 13: output register, zero vector forces a zero result
	logic [OW-1:0] dir_s13 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (fsb[3]) begin
					dir_s13[i] <= '0;
				end else if (fsb[i]) begin
					dir_s13[i] <= OW'(0) - OW'(fquo[i]);
				end else begin
					dir_s13[i] <= OW'(fquo[i]);
				end
			end
		end
	end

	assign dir.valid = vld_s13;
	assign dir.dir_x = signed'(dir_s13[0]);
	assign dir.dir_y = signed'(dir_s13[1]);
	assign dir.dir_z = signed'(dir_s13[2]);

endmodule

@@ rtl/core/prd_div.sv @@
`timescale 1ns / 1ps
module prd_div import prd_pkg::*; #(
	parameter int LANES = 2,
	parameter int NW    = 37,
	parameter int DW    = 17,
	parameter int QW    = 37,
	parameter int SBW   = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_vld,
	input  logic [LANES-1:0][NW-1:0]   num,
	input  logic [LANES-1:0][DW-1:0]   den,
	input  logic [SBW-1:0]             sb_in,
	output logic                       out_vld,
	output logic [LANES-1:0][QW-1:0]   quo,
	output logic [SBW-1:0]             sb_out
);

	// One quotient bit per stage; upper quotient bits are known zero
	logic                       vld_sk [QW];
	logic [LANES-1:0][DW-1:0]   rem_sk [QW];
	logic [LANES-1:0][DW-1:0]   den_sk [QW];
	logic [LANES-1:0][NW-1:0]   num_sk [QW];
	logic [LANES-1:0][QW-1:0]   quo_sk [QW];
	logic [SBW-1:0]             sb_sk  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic                     vld_p;
		logic [LANES-1:0][DW-1:0] rem_p;
		logic [LANES-1:0][DW-1:0] den_p;
		logic [LANES-1:0][NW-1:0] num_p;
		logic [LANES-1:0][QW-1:0] quo_p;
		logic [SBW-1:0]           sb_p;
		logic [LANES-1:0][DW-1:0] rem_n;
		logic [LANES-1:0][QW-1:0] quo_n;

		if (k == 0) begin : g_first
			always_comb begin
				vld_p = in_vld;
				den_p = den;
				num_p = num;
				sb_p  = sb_in;
				for (int l = 0; l < LANES; l++) begin
					rem_p[l] = DW'(num[l] >> QW);
					quo_p[l] = '0;
				end
			end
		end else begin : g_next
			assign vld_p = vld_sk[k-1];
			assign rem_p = rem_sk[k-1];
			assign den_p = den_sk[k-1];
			assign num_p = num_sk[k-1];
			assign quo_p = quo_sk[k-1];
			assign sb_p  = sb_sk[k-1];
		end

		// Shift in the next numerator bit and try the subtract
		always_comb begin
			logic [DW:0] trial;
			logic        ge;
			for (int l = 0; l < LANES; l++) begin
				trial    = {rem_p[l], num_p[l][QW-1-k]};
				ge       = (trial >= {1'b0, den_p[l]});
				rem_n[l] = ge ? DW'(trial - {1'b0, den_p[l]}) : trial[DW-1:0];
				quo_n[l] = {quo_p[l][QW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k] <= 1'b0;
			end else if (en) begin
				vld_sk[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k] <= rem_n;
				den_sk[k] <= den_p;
				num_sk[k] <= num_p;
				quo_sk[k] <= quo_n;
				sb_sk[k]  <= sb_p;
			end
		end
	end

	assign out_vld = vld_sk[QW-1];
	assign quo     = quo_sk[QW-1];
	assign sb_out  = sb_sk[QW-1];

endmodule

@@ rtl/core/prd_isqrt.sv @@
`timescale 1ns / 1ps
module prd_isqrt import prd_pkg::*; #(
	parameter int SBW = 97
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [RAD_W-1:0]  rad,
	input  logic [SBW-1:0]    sb_in,
	output logic              out_vld,
	output logic [ROOT_W-1:0] root,
	output logic [SBW-1:0]    sb_out
);

	// One digit-pair per stage, test bit walks down from bit 62
	logic             vld_sk [ISQRT_STEPS];
	logic [RAD_W-1:0] rem_sk [ISQRT_STEPS];
	logic [RAD_W-1:0] res_sk [ISQRT_STEPS];
	logic [SBW-1:0]   sb_sk  [ISQRT_STEPS];

	for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_stage
		localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
		logic             vld_p;
		logic [RAD_W-1:0] rem_p;
		logic [RAD_W-1:0] res_p;
		logic [SBW-1:0]   sb_p;
		logic [RAD_W-1:0] rem_n;
		logic [RAD_W-1:0] res_n;

		if (k == 0) begin : g_first
			assign vld_p = in_vld;
			assign rem_p = rad;
			assign res_p = '0;
			assign sb_p  = sb_in;
		end else begin : g_next
			assign vld_p = vld_sk[k-1];
			assign rem_p = rem_sk[k-1];
			assign res_p = res_sk[k-1];
			assign sb_p  = sb_sk[k-1];
		end

		always_comb begin
			logic [RAD_W-1:0] trial;
			trial = res_p + BIT;
			if (rem_p >= trial) begin
				rem_n = rem_p - trial;
				res_n = (res_p >> 1) + BIT;
			end else begin
				rem_n = rem_p;
				res_n = res_p >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sk[k] <= 1'b0;
			end else if (en) begin
				vld_sk[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k] <= rem_n;
				res_sk[k] <= res_n;
				sb_sk[k]  <= sb_p;
			end
		end
	end

	assign out_vld = vld_sk[ISQRT_STEPS-1];
	assign root    = res_sk[ISQRT_STEPS-1][ROOT_W-1:0];
	assign sb_out  = sb_sk[ISQRT_STEPS-1];

endmodule

@@ tb/sv/pinhole_primary_ray_direction_checker.sv @@
`timescale 1ns / 1ps
module pinhole_primary_ray_direction_checker import prd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	prd_cfg_if   cfg,
	prd_pix_if   pix,
	prd_dir_if   dir,
	output int   mismatches,
	output int   outstanding
);

	localparam int FB = DEF_DIR_FRAC_BITS;
	localparam int CF = COORD_W - DEF_COORD_INT_BITS;
	localparam int OW = FB + 2;

	typedef struct packed {
		logic [OW-1:0] x;
		logic [OW-1:0] y;
		logic [OW-1:0] z;
	} ray_dir_t;

	// Shadow copy of the camera registers
	logic [SIZE_W-1:0] cam_width;
	logic [SIZE_W-1:0] cam_height;
	logic [FOV_W-1:0]  cam_tan;
	logic [FOV_W-1:0]  cam_aspect;
	logic [ROW_W-1:0]  cam_rot [3];

	ray_dir_t pending_rays [$];

	function automatic longint unsigned pixel_ratio(longint unsigned coord,
			longint unsigned size);
		longint unsigned den;
		if (size == 0)
			size = 1;
		den = size << CF;
		return ((coord << (FB + 1)) + den / 2) / den;
	endfunction

	function automatic longint clamp_scale(longint v, longint unsigned p);
		longint unsigned mag, r;
		longint unsigned top;
		mag = (v < 0) ? longint'(-v) : v;
		top = 64'd1 << (FB + 1);
		if (p != 0 && mag > (64'd1 << (FB + 17)) / p)
			r = top;
		else
			r = (mag * p + (64'd1 << 15)) >> 16;
		if (v < 0) begin
			if (r > top)
				r = top;
			return -longint'(r);
		end
		if (r > top - 1)
			r = top - 1;
		return longint'(r);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s)
			bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic ray_dir_t trace_direction(logic [COORD_W-1:0] px,
			logic [COORD_W-1:0] py);
		longint unsigned p16, mx, sum, norm, q;
		longint unsigned mag [3];
		longint c [3];
		longint w [3];
		logic signed [MAT_W-1:0] e;
		logic [OW-1:0] o [3];
		int nbits;
		ray_dir_t r;
		p16 = (64'(cam_aspect) * 64'(cam_tan) + (64'd1 << 15)) >> 16;
		c[0] = clamp_scale(longint'(pixel_ratio(64'(px), 64'(cam_width))) -
			(64'sd1 <<< FB), p16);
		c[1] = clamp_scale((64'sd1 <<< FB) -
			longint'(pixel_ratio(64'(py), 64'(cam_height))), 64'(cam_tan));
		c[2] = -(64'sd1 <<< FB);
		mx = 0;
		// Rotate into world space
		for (int i = 0; i < 3; i++) begin
			w[i] = 0;
			for (int j = 0; j < 3; j++) begin
				e = cam_rot[i][MAT_W*j +: MAT_W];
				w[i] += longint'(e) * c[j];
			end
			mag[i] = (w[i] < 0) ? longint'(-w[i]) : w[i];
			if (mag[i] > mx)
				mx = mag[i];
		end
		// Degenerate rotation gives a zero vector
		if (mx == 0)
			return '0;
		nbits = 0;
		while (nbits < 64 && (mx >> nbits) != 0)
			nbits++;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			if (nbits > NORM_BITS)
				mag[i] >>= (nbits - NORM_BITS);
			else
				mag[i] <<= (NORM_BITS - nbits);
			sum += mag[i] * mag[i];
		end
		norm = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << FB) + norm / 2) / norm;
			o[i] = (w[i] < 0) ? OW'(-q) : OW'(q);
		end
		r.x = o[0];
		r.y = o[1];
		r.z = o[2];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [OW-1:0] got, logic [OW-1:0] want);
		$display("%0t: %s mismatch: got %0d expected %0d", $time, what,
			$signed(got), $signed(want));
		mismatches++;
	endtask

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	// Sample each channel mid-cycle; a transaction completes at the next rising edge
	always @(negedge clk) begin
		ray_dir_t want;
		if (!arst_n) begin
			cam_width = SIZE_RST;
			cam_height = SIZE_RST;
			cam_tan = FOV_RST;
			cam_aspect = FOV_RST;
			cam_rot[0] = ROW0_RST;
			cam_rot[1] = ROW1_RST;
			cam_rot[2] = ROW2_RST;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_IMAGE_WIDTH:      cam_width = cfg.data[SIZE_W-1:0];
					REG_IMAGE_HEIGHT:     cam_height = cfg.data[SIZE_W-1:0];
					REG_HALF_FOV_TANGENT: cam_tan = cfg.data[FOV_W-1:0];
					REG_ASPECT_RATIO:     cam_aspect = cfg.data[FOV_W-1:0];
					REG_ROTATION_ROW0:    cam_rot[0] = cfg.data;
					REG_ROTATION_ROW1:    cam_rot[1] = cfg.data;
					REG_ROTATION_ROW2:    cam_rot[2] = cfg.data;
					default: ;
				endcase
			end
			if (pix.valid && pix.ready)
				pending_rays.push_back(trace_direction(pix.pixel_x, pix.pixel_y));
			if (dir.valid && dir.ready) begin
				if (pending_rays.size() == 0) begin
					$display("%0t: direction with no pixel pending", $time);
					mismatches++;
				end else begin
					want = pending_rays.pop_front();
					if (dir.dir_x !== want.x)
						report_mismatch("dir_x", dir.dir_x, want.x);
					if (dir.dir_y !== want.y)
						report_mismatch("dir_y", dir.dir_y, want.y);
					if (dir.dir_z !== want.z)
						report_mismatch("dir_z", dir.dir_z, want.z);
				end
			end
		end
		outstanding = pending_rays.size();
	end

endmodule

@@ tb/sv/pinhole_primary_ray_direction_test.sv @@
`timescale 1ns / 1ps
module pinhole_primary_ray_direction_test;
	import prd_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 2 * DEF_DIR_FRAC_BITS + 64 + 20;

	typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;

	logic clk;
	logic arst_n;
	int mismatches;
	int outstanding;
	int cycle_count;
	idle_mode_t idle_mode;
	int hold_request;
	int hold_seen;
	int hold_left;

	prd_cfg_if cfg ();
	prd_pix_if pix ();
	prd_dir_if dir ();

	pinhole_primary_ray_direction dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pix    (pix),
		.dir    (dir)
	);

	pinhole_primary_ray_direction_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.pix         (pix),
		.dir         (dir),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[pinhole_primary_ray_direction] ERROR");
			$finish;
		end
	end

	// Drive dir.ready; a long hold-off runs down its own counter
	always @(posedge clk) begin
		if (hold_request != hold_seen) begin
			hold_seen <= hold_request;
			hold_left <= 400;
			dir.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			dir.ready <= 1'b0;
		end else begin
			case (idle_mode)
				IDLE_RECEIVER: dir.ready <= ($urandom_range(99) >= 72);
				IDLE_BOTH:     dir.ready <= ($urandom_range(99) >= 6);
				default:       dir.ready <= 1'b1;
			endcase
		end
	end

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		logic ok;
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do begin
			@(negedge clk);
			ok = cfg.ready;
			@(posedge clk);
		end while (!ok);
		cfg.valid <= 1'b0;
	endtask

	task automatic send_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		logic ok;
		int pct;
		pct = (idle_mode == IDLE_SENDER) ? 72 : (idle_mode == IDLE_BOTH) ? 6 : 0;
		if ($urandom_range(99) < pct) begin
			pix.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < pct);
		end
		pix.valid <= 1'b1;
		pix.pixel_x <= x;
		pix.pixel_y <= y;
		do begin
			@(negedge clk);
			ok = pix.ready;
			@(posedge clk);
		end while (!ok);
	endtask

	// Let the pipeline empty before touching registers
	task automatic drain;
		pix.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [ROW_W-1:0] random_row();
		return ROW_W'({$urandom, $urandom});
	endfunction

	// Mostly inside the image, sometimes anywhere
	function automatic logic [COORD_W-1:0] random_coord(int size);
		int span;
		span = ((size == 0) ? 1 : size) * 16;
		if ($urandom_range(9) == 0 || span > 65535)
			return COORD_W'($urandom);
		return COORD_W'($urandom_range(span - 1));
	endfunction

	task automatic random_camera(output int w, output int h);
		w = ($urandom_range(3) == 0) ? $urandom_range(8191) : $urandom_range(1, 64);
		h = ($urandom_range(3) == 0) ? $urandom_range(8191) : $urandom_range(1, 64);
		write_register(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
		write_register(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
		write_register(REG_HALF_FOV_TANGENT, CFG_DATA_W'(($urandom_range(3) == 0) ?
			$urandom : $urandom_range(20000, 150000)));
		write_register(REG_ASPECT_RATIO, CFG_DATA_W'(($urandom_range(3) == 0) ?
			$urandom : $urandom_range(30000, 140000)));
		if ($urandom_range(2) == 0) begin
			write_register(REG_ROTATION_ROW0, ROW0_RST);
			write_register(REG_ROTATION_ROW1, ROW1_RST);
			write_register(REG_ROTATION_ROW2, ROW2_RST);
		end else begin
			write_register(REG_ROTATION_ROW0, random_row());
			write_register(REG_ROTATION_ROW1, random_row());
			write_register(REG_ROTATION_ROW2, random_row());
		end
	endtask

	initial begin
		int w, h;
		arst_n = 1'b0;
		cycle_count = 0;
		idle_mode = IDLE_NONE;
		hold_request = 0;
		hold_seen = 0;
		hold_left = 0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		pix.valid = 1'b0;
		pix.pixel_x = '0;
		pix.pixel_y = '0;
		dir.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes on the reset camera
		send_pixel(16'd0, 16'd0);
		send_pixel(16'hFFFF, 16'hFFFF);
		send_pixel(16'd8192, 16'd8192);
		send_pixel(16'd16383, 16'd0);
		send_pixel(16'd0, 16'd16384);
		send_pixel(16'hAAAA, 16'h5555);
		drain();

		// Zero image size and extreme lens values
		write_register(REG_IMAGE_WIDTH, CFG_DATA_W'(0));
		write_register(REG_IMAGE_HEIGHT, CFG_DATA_W'(8191));
		write_register(REG_HALF_FOV_TANGENT, CFG_DATA_W'(20'hFFFFF));
		write_register(REG_ASPECT_RATIO, CFG_DATA_W'(20'hFFFFF));
		write_register(3'd7, {CFG_DATA_W{1'b1}});
		send_pixel(16'd0, 16'd0);
		send_pixel(16'd8, 16'hFFFF);
		send_pixel(16'hFFFF, 16'd1);
		drain();
		write_register(REG_IMAGE_WIDTH, CFG_DATA_W'(1));
		write_register(REG_IMAGE_HEIGHT, CFG_DATA_W'(0));
		write_register(REG_HALF_FOV_TANGENT, CFG_DATA_W'(0));
		write_register(REG_ASPECT_RATIO, CFG_DATA_W'(0));
		write_register(REG_ROTATION_ROW0, {3{21'h100000}});
		write_register(REG_ROTATION_ROW1, {3{21'h0FFFFF}});
		write_register(REG_ROTATION_ROW2, {CFG_DATA_W{1'b1}});
		send_pixel(16'd0, 16'd0);
		send_pixel(16'd16, 16'd16);
		send_pixel(16'hFFFF, 16'hFFFF);
		drain();

		// Degenerate rotation: zero matrix
		write_register(REG_ROTATION_ROW0, '0);
		write_register(REG_ROTATION_ROW1, '0);
		write_register(REG_ROTATION_ROW2, '0);
		send_pixel(16'd100, 16'd200);
		send_pixel(16'hFFFF, 16'd0);
		drain();

		// Random phases over every idling mode
		for (int phase = 0; phase < 8; phase++) begin
			random_camera(w, h);
			idle_mode = idle_mode_t'(phase % 4);
			for (int n = 0; n < 105; n++) begin
				if (phase == 1 && n == 10)
					hold_request = hold_request + 1;
				send_pixel(random_coord(w), random_coord(h));
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("[pinhole_primary_ray_direction] OK");
		end else begin
			$display("[pinhole_primary_ray_direction] ERROR");
		end
		$finish;
	end

endmodule
